>>> rtl/rmts_pkg.sv
// rmts_pkg: shared types, constants and request/record codes for the
// rate-monotonic tick scheduler; no dependencies
package rmts_pkg;

   localparam int MaxTasksDefault = 16;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_FINISH = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REC_TASK_RUN = 2'd0,
      REC_IDLE_RUN = 2'd1,
      REC_COUNTERS = 2'd2
   } rec_kind_type;

   typedef enum logic [0:0] {
      CSR_PERIOD_LIMIT = 1'd0,
      CSR_SEGMENT_CAP  = 1'd1
   } csr_index_type;

   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  period;
      logic [15:0]  burst;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RELEASE,
      BK_SELECT,
      BK_EXEC,
      BK_EMIT,
      BK_LOAD,
      BK_FINISH
   } bk_state_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

>>> rtl/rmts_front.sv
// rmts_front: accepts requests, drops ignored codes, and holds a two-entry
// command queue toward the execution engine; depends on rmts_pkg
module rmts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [15:0]           req_task_period,
   input  logic [15:0]           req_task_burst,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output rmts_pkg::cmd_type     cmd
);

   rmts_pkg::cmd_type q_ff [2];
   rmts_pkg::cmd_type q_in [2];
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   rmts_pkg::cmd_type incoming;

   assign req_ready = (cnt_ff != 2'd2);
   assign incoming.kind   = rmts_pkg::req_kind_type'(req_type);
   assign incoming.period = req_task_period;
   assign incoming.burst  = req_task_burst;
   assign push = req_valid && req_ready && (req_type != rmts_pkg::REQ_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];
   assign pop = cmd_valid && cmd_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) q_in[0] = incoming;
         else                q_in[1] = incoming;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/rmts_engine.sv
// rmts_engine: task table and tick/load/finish sequencer, one slot per cycle,
// with a registered result stage; depends on rmts_pkg
module rmts_engine #(
   parameter int MAX_TASKS = rmts_pkg::MaxTasksDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  rmts_pkg::cmd_type     cmd,
   input  logic [15:0]           period_limit,
   input  logic [15:0]           segment_cap,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_record_kind,
   output logic [3:0]            rsp_task_id,
   output logic [15:0]           rsp_run_length,
   output logic                  rsp_run_finished,
   output logic [31:0]           rsp_missed_count,
   output logic [31:0]           rsp_completed_count,
   output logic                  rsp_last_of_run
);

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [15:0] per_ff  [MAX_TASKS];
   logic [15:0] bur_ff  [MAX_TASKS];
   logic [3:0]  id_ff   [MAX_TASKS];
   logic [31:0] rel_ff  [MAX_TASKS];
   logic [31:0] dl_ff   [MAX_TASKS];
   logic [15:0] wl_ff   [MAX_TASKS];
   logic [31:0] miss_ff [MAX_TASKS];
   logic [31:0] done_ff [MAX_TASKS];

   logic [CW-1:0]  count_ff;
   logic [31:0]    now_ff;
   logic           rv_ff;
   logic [SW-1:0]  rs_ff;
   logic [15:0]    rt_ff;
   logic [CW-1:0]  idx_ff;
   logic           found_ff;
   logic [SW-1:0]  chosen_ff;
   logic           fin_last_ff;
   rmts_pkg::bk_state_type st_ff, st_in;
   rmts_pkg::cmd_type      c_ff;

   logic        ov_ff;
   logic [1:0]  okind_ff;
   logic [3:0]  oid_ff;
   logic [15:0] olen_ff;
   logic        ofin_ff;
   logic [31:0] omiss_ff, odone_ff;
   logic        olast_ff;

   logic [SW-1:0] ix, ixp;
   logic          out_free;
   logic          changed, report;
   logic          load_drop, shift, fin_none;
   logic          emit_run, emit_idle, emit_fin;

   assign ix = idx_ff[SW-1:0];
   assign ixp = SW'(idx_ff - CW'(1));
   assign out_free = !ov_ff || rsp_ready;
   assign cmd_ready = (st_ff == rmts_pkg::BK_IDLE);

   assign rsp_valid           = ov_ff;
   assign rsp_record_kind     = okind_ff;
   assign rsp_task_id         = oid_ff;
   assign rsp_run_length      = olen_ff;
   assign rsp_run_finished    = ofin_ff;
   assign rsp_missed_count    = omiss_ff;
   assign rsp_completed_count = odone_ff;
   assign rsp_last_of_run     = olast_ff;

   assign changed = (found_ff != rv_ff) || (found_ff && chosen_ff != rs_ff);
   assign report  = changed || (rt_ff >= segment_cap);

   assign load_drop = (cmd.period > period_limit) || (count_ff >= CW'(MAX_TASKS));
   assign shift     = (idx_ff != '0) && (per_ff[ixp] > c_ff.period);
   assign fin_none  = !rv_ff && (count_ff == '0);

   assign emit_run  = (st_ff == rmts_pkg::BK_EMIT) && out_free && report && rv_ff;
   assign emit_idle = (st_ff == rmts_pkg::BK_EMIT) && out_free && report && !rv_ff &&
                      (now_ff != '0) && (rt_ff != '0);
   assign emit_fin  = (st_ff == rmts_pkg::BK_FINISH) && out_free && !fin_none;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         rmts_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  rmts_pkg::REQ_LOAD: begin
                     if (!load_drop) st_in = rmts_pkg::BK_LOAD;
                  end
                  rmts_pkg::REQ_TICK: begin
                     if (count_ff == '0) st_in = rmts_pkg::BK_EMIT;
                     else                st_in = rmts_pkg::BK_RELEASE;
                  end
                  rmts_pkg::REQ_FINISH: st_in = rmts_pkg::BK_FINISH;
                  default:              st_in = rmts_pkg::BK_IDLE;
               endcase
            end
         end
         rmts_pkg::BK_RELEASE:
            if (idx_ff + CW'(1) >= count_ff) st_in = rmts_pkg::BK_SELECT;
         rmts_pkg::BK_SELECT:
            if (idx_ff + CW'(1) >= count_ff) st_in = rmts_pkg::BK_EMIT;
         rmts_pkg::BK_EMIT:
            if (out_free) st_in = rmts_pkg::BK_EXEC;
         rmts_pkg::BK_EXEC:   st_in = rmts_pkg::BK_IDLE;
         rmts_pkg::BK_LOAD:
            if (!shift) st_in = rmts_pkg::BK_IDLE;
         rmts_pkg::BK_FINISH:
            if (fin_none || (out_free && fin_last_ff)) st_in = rmts_pkg::BK_IDLE;
         default: st_in = rmts_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= rmts_pkg::BK_IDLE;
         count_ff <= '0;
         now_ff   <= '0;
         rv_ff    <= 1'b0;
         rs_ff    <= '0;
         rt_ff    <= '0;
         ov_ff    <= 1'b0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         chosen_ff <= '0;
         fin_last_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit_run || emit_idle || emit_fin) ov_ff <= 1'b1;
         else if (rsp_ready)                    ov_ff <= 1'b0;
         unique case (st_ff)
            rmts_pkg::BK_IDLE: begin
               c_ff        <= cmd;
               found_ff    <= 1'b0;
               fin_last_ff <= !rv_ff && (count_ff == CW'(1));
               if (cmd_valid && cmd.kind == rmts_pkg::REQ_LOAD) idx_ff <= count_ff;
               else                                              idx_ff <= '0;
            end
            rmts_pkg::BK_RELEASE: begin
               if (rel_ff[ix] == now_ff) begin
                  if (wl_ff[ix] != '0) miss_ff[ix] <= rmts_pkg::sat_inc32(miss_ff[ix]);
                  wl_ff[ix]  <= bur_ff[ix];
                  dl_ff[ix]  <= now_ff + {16'd0, per_ff[ix]};
                  rel_ff[ix] <= rel_ff[ix] + {16'd0, per_ff[ix]};
               end
               idx_ff <= (idx_ff + CW'(1) >= count_ff) ? '0 : idx_ff + CW'(1);
            end
            rmts_pkg::BK_SELECT: begin
               if (!found_ff && wl_ff[ix] != '0) begin
                  found_ff  <= 1'b1;
                  chosen_ff <= ix;
               end
               idx_ff <= idx_ff + CW'(1);
            end
            rmts_pkg::BK_EMIT: begin
               if (emit_run) begin
                  okind_ff <= rmts_pkg::REC_TASK_RUN;
                  oid_ff   <= id_ff[rs_ff];
                  olen_ff  <= rt_ff;
                  ofin_ff  <= (wl_ff[rs_ff] == '0);
                  omiss_ff <= '0;
                  odone_ff <= '0;
                  olast_ff <= 1'b1;
               end else if (emit_idle) begin
                  okind_ff <= rmts_pkg::REC_IDLE_RUN;
                  oid_ff   <= '0;
                  olen_ff  <= rt_ff;
                  ofin_ff  <= 1'b0;
                  omiss_ff <= '0;
                  odone_ff <= '0;
                  olast_ff <= 1'b1;
               end
               if (out_free && report) rt_ff <= '0;
            end
            rmts_pkg::BK_EXEC: begin
               if (found_ff) begin
                  if (wl_ff[chosen_ff] == 16'd1) begin
                     wl_ff[chosen_ff]   <= '0;
                     done_ff[chosen_ff] <= rmts_pkg::sat_inc32(done_ff[chosen_ff]);
                  end else if (now_ff + 32'd1 >= dl_ff[chosen_ff]) begin
                     wl_ff[chosen_ff]   <= '0;
                     miss_ff[chosen_ff] <= rmts_pkg::sat_inc32(miss_ff[chosen_ff]);
                  end else begin
                     wl_ff[chosen_ff] <= wl_ff[chosen_ff] - 16'd1;
                  end
                  rv_ff <= 1'b1;
                  rs_ff <= chosen_ff;
               end else begin
                  rv_ff <= 1'b0;
               end
               if (rt_ff != 16'hFFFF) rt_ff <= rt_ff + 16'd1;
               now_ff <= now_ff + 32'd1;
            end
            rmts_pkg::BK_LOAD: begin
               if (shift) begin
                  per_ff[ix]  <= per_ff[ixp];
                  bur_ff[ix]  <= bur_ff[ixp];
                  id_ff[ix]   <= id_ff[ixp];
                  rel_ff[ix]  <= rel_ff[ixp];
                  dl_ff[ix]   <= dl_ff[ixp];
                  wl_ff[ix]   <= wl_ff[ixp];
                  miss_ff[ix] <= miss_ff[ixp];
                  done_ff[ix] <= done_ff[ixp];
                  idx_ff <= idx_ff - CW'(1);
               end else begin
                  per_ff[ix]  <= c_ff.period;
                  bur_ff[ix]  <= c_ff.burst;
                  id_ff[ix]   <= 4'(count_ff);
                  rel_ff[ix]  <= now_ff;
                  dl_ff[ix]   <= '0;
                  wl_ff[ix]   <= '0;
                  miss_ff[ix] <= '0;
                  done_ff[ix] <= '0;
                  if (rv_ff && rs_ff >= ix) rs_ff <= rs_ff + SW'(1);
                  count_ff <= count_ff + CW'(1);
                  idx_ff   <= '0;
               end
            end
            rmts_pkg::BK_FINISH: begin
               if (fin_none) begin
                  count_ff <= '0;
                  now_ff   <= '0;
                  rs_ff    <= '0;
                  rt_ff    <= '0;
               end else if (out_free) begin
                  if (rv_ff) begin
                     okind_ff <= rmts_pkg::REC_TASK_RUN;
                     oid_ff   <= id_ff[rs_ff];
                     olen_ff  <= rt_ff;
                     ofin_ff  <= (wl_ff[rs_ff] == '0);
                     omiss_ff <= '0;
                     odone_ff <= '0;
                     olast_ff <= 1'b0;
                     rv_ff    <= 1'b0;
                     fin_last_ff <= (count_ff == CW'(1));
                  end else begin
                     okind_ff <= rmts_pkg::REC_COUNTERS;
                     oid_ff   <= id_ff[ix];
                     olen_ff  <= '0;
                     ofin_ff  <= 1'b0;
                     omiss_ff <= miss_ff[ix];
                     odone_ff <= done_ff[ix];
                     olast_ff <= fin_last_ff;
                     if (fin_last_ff) begin
                        count_ff <= '0;
                        now_ff   <= '0;
                        rs_ff    <= '0;
                        rt_ff    <= '0;
                     end else begin
                        idx_ff      <= idx_ff + CW'(1);
                        fin_last_ff <= (idx_ff + CW'(2) >= count_ff);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/rate_monotonic_tick_scheduler_unit.sv
// rate_monotonic_tick_scheduler_unit: top level with the register port,
// request front end and execution engine; depends on rmts_pkg, rmts_front,
// rmts_engine
//
// requests arrive on req_ (valid/ready): load a task, advance one tick,
// or finish. ignored request codes are dropped in the front end.
// a two-entry queue parts the front end from the execution engine.
// results leave on rsp_ (valid/ready) from one output register;
// last_of_run marks the final result of a request.
// a load inserts the task by period (insertion shift of one slot per cycle)
// a tick runs accept, release walk and priority walk of one table slot per
// cycle (both walks skipped when no task is loaded), report, execute
// finish gives one result per cycle while rsp_ready is high
// a stalled receiver holds the engine in its report step; the queue keeps
// taking requests until full
// reset (synchronous, active high) empties the table and restores both
// registers to 65535
module rate_monotonic_tick_scheduler_unit #(
   parameter int MAX_TASKS = rmts_pkg::MaxTasksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_task_period,
   input  logic [15:0] req_task_burst,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [3:0]  rsp_task_id,
   output logic [15:0] rsp_run_length,
   output logic        rsp_run_finished,
   output logic [31:0] rsp_missed_count,
   output logic [31:0] rsp_completed_count,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] limit_ff, cap_ff;
   logic        wr;
   rmts_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign wr        = psel && penable && pwrite;
   assign csr_index = rmts_pkg::csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hFFFF;
         cap_ff   <= 16'hFFFF;
      end else if (wr) begin
         unique case (csr_index)
            rmts_pkg::CSR_PERIOD_LIMIT: limit_ff <= pwdata[15:0];
            rmts_pkg::CSR_SEGMENT_CAP:  cap_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rmts_pkg::CSR_PERIOD_LIMIT: prdata = {16'd0, limit_ff};
         rmts_pkg::CSR_SEGMENT_CAP:  prdata = {16'd0, cap_ff};
         default:                    prdata = '0;
      endcase
   end

   logic              cmd_valid, cmd_ready;
   rmts_pkg::cmd_type cmd;

   rmts_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .req_task_period, .req_task_burst,
      .cmd_valid, .cmd_ready, .cmd
   );

   rmts_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .period_limit(limit_ff), .segment_cap(cap_ff),
      .rsp_valid, .rsp_ready, .rsp_record_kind, .rsp_task_id,
      .rsp_run_length, .rsp_run_finished, .rsp_missed_count,
      .rsp_completed_count, .rsp_last_of_run
   );

endmodule
